/* hdl/png_scanline_unfilter_macros.svh */
// ============================================================================
// png_scanline_unfilter_macros.svh
// Assertion macros used by the checker of the scanline unfilter.
// ============================================================================
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Same-cycle implication, disabled while the given condition holds.
`define PNGU_ASSERT_NOW(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("png_scanline_unfilter check failed");

// Next-cycle implication, disabled while the given condition holds.
`define PNGU_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("png_scanline_unfilter check failed");

`endif

/* hdl/pngu_pkg.sv */
// ============================================================================
// pngu_pkg
// Types and constants of the PNG scanline unfilter.
// ============================================================================
package pngu_pkg;

   localparam int BYTE_W     = 8;
   localparam int BPP_W      = 3;
   localparam int ROW_LEN_W  = 14;
   localparam int HIST_DEPTH = 4;
   localparam int HIST_IDX_W = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 14;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_LENGTH      = 1'd1;

   // Register reset values.
   localparam logic [BPP_W-1:0]     BPP_RESET     = 3'd4;
   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 14'd8192;

   // Filter type codes.
   localparam logic [BYTE_W-1:0] FILTER_NONE  = 8'd0;
   localparam logic [BYTE_W-1:0] FILTER_SUB   = 8'd1;
   localparam logic [BYTE_W-1:0] FILTER_UP    = 8'd2;
   localparam logic [BYTE_W-1:0] FILTER_AVG   = 8'd3;
   localparam logic [BYTE_W-1:0] FILTER_PAETH = 8'd4;

   typedef logic [BYTE_W-1:0] byte_type;

   // Neighbors of the byte being reconstructed.
   typedef struct packed {
      byte_type left;
      byte_type upper;
      byte_type upper_left;
   } nbr_type;

endpackage

/* hdl/pngu_req_if.sv */
// ============================================================================
// pngu_req_if
// Input channel: filtered bytes of the decompressed stream.
// ============================================================================
interface pngu_req_if
   import pngu_pkg::*;
();

   logic     valid;
   logic     ready;
   byte_type raw_byte;
   logic     image_start;

   modport source (output valid, output raw_byte, output image_start, input ready);
   modport sink   (input valid, input raw_byte, input image_start, output ready);

endinterface

/* hdl/pngu_rsp_if.sv */
// ============================================================================
// pngu_rsp_if
// Result channel: reconstructed image bytes.
// ============================================================================
interface pngu_rsp_if
   import pngu_pkg::*;
();

   logic     valid;
   logic     ready;
   byte_type pixel_byte;
   logic     row_end;

   modport source (output valid, output pixel_byte, output row_end, input ready);
   modport sink   (input valid, input pixel_byte, input row_end, output ready);

endinterface

/* hdl/pngu_ram.sv */
// ============================================================================
// pngu_ram
// Simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module pngu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; a read of the entry being written returns the old data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pngu_predict.sv */
// ============================================================================
// pngu_predict
// Predictor selection and byte reconstruction for the five PNG filters.
// ============================================================================
module pngu_predict
   import pngu_pkg::*;
(
   input  byte_type filter,
   input  nbr_type  nbr,
   input  byte_type raw_byte,
   output byte_type pixel_byte
);

   logic signed [9:0] diff_bc;
   logic signed [9:0] diff_ac;
   logic signed [9:0] diff_p;
   logic        [8:0] dist_a;
   logic        [8:0] dist_b;
   logic        [8:0] dist_c;
   logic        [8:0] avg_sum;
   byte_type          paeth;
   byte_type          pred;

   // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
   always_comb begin
      diff_bc = signed'({2'b00, nbr.upper}) - signed'({2'b00, nbr.upper_left});
      diff_ac = signed'({2'b00, nbr.left})  - signed'({2'b00, nbr.upper_left});
      diff_p  = diff_bc + diff_ac;
      dist_a  = diff_bc[9] ? 9'(-diff_bc) : diff_bc[8:0];
      dist_b  = diff_ac[9] ? 9'(-diff_ac) : diff_ac[8:0];
      dist_c  = diff_p[9]  ? 9'(-diff_p)  : diff_p[8:0];
      if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
         paeth = nbr.left;
      end else if (dist_b <= dist_c) begin
         paeth = nbr.upper;
      end else begin
         paeth = nbr.upper_left;
      end
   end

   // Predictor by filter type; unknown types add nothing.
   always_comb begin
      avg_sum = {1'b0, nbr.left} + {1'b0, nbr.upper};
      case (filter)
         FILTER_NONE:  pred = '0;
         FILTER_SUB:   pred = nbr.left;
         FILTER_UP:    pred = nbr.upper;
         FILTER_AVG:   pred = avg_sum[8:1];
         FILTER_PAETH: pred = paeth;
         default:      pred = '0;
      endcase
   end

   assign pixel_byte = raw_byte + pred;

endmodule

/* hdl/png_scanline_unfilter.sv */
// ============================================================================
// png_scanline_unfilter
// PNG filter reconstruction (None, Sub, Up, Average, Paeth), one byte a cycle unless stalled.
// ============================================================================
// The block takes one byte per cycle while the result channel is not stalled
// and, for a data byte, shows its reconstructed value on the result channel
// in the next cycle; the filter byte at the head of each row gives no result,
// so a row of N data bytes occupies N+1 input transactions. The rate is set by
// the line store, a RAM with a registered read: its read address is the
// column of the next byte, issued in the cycle before that byte arrives, so
// the upper byte is ready when the byte is taken. The left and upper-left
// neighbors come from four-deep shift registers selected by the pixel size.
// The line store needs no clearing after reset; an image must start with a
// row flagged by image_start, and no row may be longer than a row stored
// before it.
module png_scanline_unfilter
   import pngu_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   pngu_req_if.sink              req,
   pngu_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_ROW_BYTES);
   localparam int CW = (AW + 1 > ROW_LEN_W) ? AW + 1 : ROW_LEN_W;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_ROW_BYTES);

   // Configuration registers.
   logic [BPP_W-1:0]     bpp_ff;
   logic [ROW_LEN_W-1:0] row_len_ff;

   // Row state.
   logic [AW-1:0] col_ff,    col_in;
   byte_type      filter_ff, filter_in;
   logic          await_ff,  await_in;
   logic          upper_ff,  upper_in;
   byte_type      left_ff      [HIST_DEPTH];
   byte_type      left_in      [HIST_DEPTH];
   byte_type      up_left_ff   [HIST_DEPTH];
   byte_type      up_left_in   [HIST_DEPTH];

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type pixel_ff,     pixel_in;
   logic     row_end_ff,   row_end_in;

   logic [HIST_IDX_W-1:0] sel;
   logic [CW-1:0]         len;
   logic [CW-1:0]         col_next;
   logic                  last;
   logic                  fire;
   logic                  data_fire;
   byte_type              upper_rd;
   nbr_type               nbr;
   byte_type              pixel;

   // Handshake: the result register frees up as it is emptied.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;
   assign data_fire = fire && !await_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_RESET;
         row_len_ff <= ROW_LEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff     <= csr_wr_data[BPP_W-1:0];
            CSR_ROW_LENGTH:      row_len_ff <= csr_wr_data[ROW_LEN_W-1:0];
            default:             ;
         endcase
      end
   end

   // Clamp the pixel size to 1..4 bytes and the row length to 1..max.
   always_comb begin
      if (bpp_ff inside {[3'd4:3'd7]}) begin
         sel = HIST_IDX_W'(HIST_DEPTH - 1);
      end else if (bpp_ff == 3'd0) begin
         sel = '0;
      end else begin
         sel = HIST_IDX_W'(bpp_ff - 3'd1);
      end
      if (row_len_ff == '0) begin
         len = CW'(1);
      end else if (CW'(row_len_ff) > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = CW'(row_len_ff);
      end
      col_next = CW'(col_ff) + CW'(1);
      last     = col_next >= len;
   end

   // Neighbor bytes; outside the image they read as zero.
   always_comb begin
      nbr.left       = left_ff[sel];
      nbr.upper      = upper_ff ? upper_rd : '0;
      nbr.upper_left = upper_ff ? up_left_ff[sel] : '0;
   end

   pngu_predict u_predict (
      .filter     (filter_ff),
      .nbr        (nbr),
      .raw_byte   (req.raw_byte),
      .pixel_byte (pixel)
   );

   // Line store: read the next column ahead, write back the reconstructed row.
   pngu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line (
      .clock   (clock),
      .wr_en   (data_fire),
      .wr_addr (col_ff),
      .wr_data (pixel),
      .rd_addr (col_in),
      .rd_data (upper_rd)
   );

   // Next-state logic of the row sequencer.
   always_comb begin
      col_in       = col_ff;
      filter_in    = filter_ff;
      await_in     = await_ff;
      upper_in     = upper_ff;
      left_in      = left_ff;
      up_left_in   = up_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pixel_in     = pixel_ff;
      row_end_in   = row_end_ff;
      if (fire && await_ff) begin
         filter_in = req.raw_byte;
         await_in  = 1'b0;
         col_in    = '0;
         if (req.image_start) begin
            upper_in = 1'b0;
         end
         for (int k = 0; k < HIST_DEPTH; k++) begin
            left_in[k]    = '0;
            up_left_in[k] = '0;
         end
      end else if (data_fire) begin
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            left_in[k]    = left_ff[k-1];
            up_left_in[k] = up_left_ff[k-1];
         end
         left_in[0]    = pixel;
         up_left_in[0] = nbr.upper;
         rsp_valid_in  = 1'b1;
         pixel_in      = pixel;
         row_end_in    = last;
         if (last) begin
            await_in = 1'b1;
            upper_in = 1'b1;
            col_in   = '0;
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         filter_ff    <= FILTER_NONE;
         await_ff     <= 1'b1;
         upper_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            left_ff[k]    <= '0;
            up_left_ff[k] <= '0;
         end
      end else begin
         col_ff       <= col_in;
         filter_ff    <= filter_in;
         await_ff     <= await_in;
         upper_ff     <= upper_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         up_left_ff   <= up_left_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      pixel_ff   <= pixel_in;
      row_end_ff <= row_end_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_byte = pixel_ff;
   assign rsp.row_end    = row_end_ff;

endmodule

/* hdl/pngu_checker.sv */
// ============================================================================
// pngu_checker
// Port-level checks of the scanline unfilter, bound to the top level.
// ============================================================================
`include "png_scanline_unfilter_macros.svh"

module pngu_checker
   import pngu_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type pixel_byte,
   input logic     row_end
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A stalled result holds its valid and payload.
   `PNGU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_byte) && $stable(row_end))

   // With an empty result register the input is never stalled.
   `PNGU_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A taken result with no new transaction leaves the output empty.
   `PNGU_ASSERT_NEXT(a_no_extra_rsp, clock, reset, rsp_fire && !req_fire, !rsp_valid)

   // No result right after reset.
   `PNGU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .pixel_byte (rsp.pixel_byte),
   .row_end    (rsp.row_end)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the PNG scanline unfilter.
// ============================================================================
// Rows of filtered bytes are sent through the input channel, and every
// transaction is run through a predictor of the unfilter that keeps its own
// copy of the line store and the neighbor history. Each result transaction
// is compared with the oldest predicted byte. The run first checks the reset
// pixel size on two short rows. A short directed part then covers every
// filter type, unknown types, byte extremes and stray start flags. Random
// rows follow under many pixel sizes and row lengths, with random gaps on
// both channels.
// ============================================================================
module tb;
   import pngu_pkg::*;

   localparam int ROW_STORE_DEPTH = 8192;
   localparam int RESET_CYCLES    = 7;
   localparam int MAX_GAP         = 18;
   localparam int SETTLE_CYCLES   = 4;
   localparam int END_CYCLES      = 16;
   localparam int WATCHDOG_LIMIT  = 500;
   localparam int RANDOM_ITEMS    = 560;
   localparam int REPORT_LIMIT    = 40;
   localparam int DIRECTED_ROWS   = 8;
   localparam int DIRECTED_LEN    = 2;
   localparam int FIRST_ROW_LEN   = 12;

   // Filter types above Paeth that the block passes through.
   localparam byte_type FILTER_UNKNOWN_LOW  = 8'd5;
   localparam byte_type FILTER_UNKNOWN_HIGH = 8'd255;

   typedef struct packed {
      byte_type pixel_byte;
      logic     row_end;
   } pixel_result_type;

   // Predicts reconstructed bytes and checks them against the result channel.
   class pixel_scoreboard;
      logic [BPP_W-1:0]     pixel_size;
      logic [ROW_LEN_W-1:0] row_len;
      byte_type             upper_row [ROW_STORE_DEPTH];
      byte_type             left_bytes [HIST_DEPTH];
      byte_type             upper_left_bytes [HIST_DEPTH];
      int                   column;
      byte_type             filter;
      bit                   want_filter;
      bit                   upper_ok;
      pixel_result_type     expected_pixels [$];
      int                   mismatches;

      function new();
         pixel_size  = BPP_RESET;
         row_len     = ROW_LEN_RESET;
         column      = 0;
         filter      = FILTER_NONE;
         want_filter = 1'b1;
         upper_ok    = 1'b0;
         mismatches  = 0;
         clear_history();
      endfunction

      function void clear_history();
         foreach (left_bytes[k]) begin
            left_bytes[k]       = '0;
            upper_left_bytes[k] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_BYTES_PER_PIXEL) begin
            pixel_size = data[BPP_W-1:0];
         end else if (index == CSR_ROW_LENGTH) begin
            row_len = data[ROW_LEN_W-1:0];
         end
      endfunction

      // Paeth predictor: nearest of a, b, c to a+b-c, ties go to a, then b.
      function byte_type paeth_nearest(byte_type a, byte_type b, byte_type c);
         int p, da, db, dc;
         p  = int'(a) + int'(b) - int'(c);
         da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
         db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
         dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
         if (da <= db && da <= dc) return a;
         if (db <= dc) return b;
         return c;
      endfunction

      // Called for every accepted input transaction.
      function void note_raw_byte(byte_type raw, logic start);
         int                size, len, k;
         byte_type          a, b, c, guess, y;
         logic [BYTE_W:0]   sum;
         pixel_result_type  res;
         // The first byte of a row only selects the filter.
         if (want_filter) begin
            filter      = raw;
            if (start) upper_ok = 1'b0;
            want_filter = 1'b0;
            column      = 0;
            clear_history();
            return;
         end
         size = (pixel_size < 1) ? 1 : ((pixel_size > HIST_DEPTH) ? HIST_DEPTH : pixel_size);
         len  = (row_len < 1) ? 1 : ((row_len > ROW_STORE_DEPTH) ? ROW_STORE_DEPTH : row_len);
         a = left_bytes[size-1];
         b = (upper_ok && column < ROW_STORE_DEPTH) ? upper_row[column] : '0;
         c = upper_ok ? upper_left_bytes[size-1] : '0;
         sum = a + b;
         case (filter)
            FILTER_SUB:   guess = a;
            FILTER_UP:    guess = b;
            FILTER_AVG:   guess = sum[BYTE_W:1];
            FILTER_PAETH: guess = paeth_nearest(a, b, c);
            default:      guess = '0;
         endcase
         y = raw + guess;
         // Shift the neighbor history by one byte.
         for (k = HIST_DEPTH - 1; k > 0; k--) begin
            left_bytes[k]       = left_bytes[k-1];
            upper_left_bytes[k] = upper_left_bytes[k-1];
         end
         left_bytes[0]       = y;
         upper_left_bytes[0] = b;
         if (column < ROW_STORE_DEPTH) upper_row[column] = y;
         res.pixel_byte = y;
         res.row_end    = (column + 1 >= len);
         if (res.row_end) begin
            want_filter = 1'b1;
            upper_ok    = 1'b1;
            column      = 0;
         end else begin
            column++;
         end
         expected_pixels.push_back(res);
      endfunction

      // Called for every accepted result transaction.
      function void check_pixel(byte_type pixel, logic row_end);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: unexpected result: expected none, actual %h row_end %b",
                        $time, pixel, row_end);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         if (pixel !== want.pixel_byte) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: pixel_byte mismatch: expected %h, actual %h",
                        $time, want.pixel_byte, pixel);
            mismatches++;
         end
         if (row_end !== want.row_end) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: row_end mismatch: expected %b, actual %b",
                        $time, want.row_end, row_end);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pngu_req_if req ();
   pngu_rsp_if rsp ();

   pixel_scoreboard sb;

   bit sender_idle;
   bit receiver_idle;
   int row_size;
   int stored_len;
   bit upper_valid;
   int random_items;
   int idle_cycles;

   byte_type directed_filter [DIRECTED_ROWS] = '{FILTER_NONE, FILTER_SUB, FILTER_UP,
      FILTER_AVG, FILTER_PAETH, FILTER_UNKNOWN_LOW, FILTER_UNKNOWN_HIGH, FILTER_PAETH};
   logic directed_start [DIRECTED_ROWS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
   byte_type directed_data [DIRECTED_ROWS*DIRECTED_LEN] = '{8'h00, 8'hFF, 8'hFF, 8'h01,
      8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h12, 8'h34, 8'hFF, 8'h00};
   // A start flag on a data byte must be ignored.
   logic directed_stray [DIRECTED_ROWS*DIRECTED_LEN] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

   png_scanline_unfilter #(
      .MAX_ROW_BYTES(ROW_STORE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every accepted transaction on either channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_raw_byte(req.raw_byte, req.image_start);
         if (rsp.valid && rsp.ready) sb.check_pixel(rsp.pixel_byte, rsp.row_end);
      end
   end

   // End the run if no transaction is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("png_scanline_unfilter test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: while receiver_idle is set, stall a random number of cycles before each transaction.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   // Sends one byte; valid stays high on return so back-to-back bytes flow.
   task automatic send_byte(input byte_type value, input logic start);
      int gap;
      gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.raw_byte    <= value;
      req.image_start <= start;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Sends a filter byte and one row of random data bytes.
   task automatic send_row(input logic start, input byte_type filter_code);
      int i;
      send_byte(filter_code, start);
      for (i = 0; i < row_size; i++)
         send_byte(byte_type'($urandom), $urandom_range(0, 3) == 0);
      if (row_size > stored_len) stored_len = row_size;
      upper_valid = 1'b1;
   endtask

   // Holds the input side until every predicted byte has come out.
   task automatic wait_for_pixels();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on consecutive cycles; only called while idle.
   task automatic write_config(input int bpp_value, input int len_value);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_BYTES_PER_PIXEL;
      csr_wr_data <= CSR_DATA_W'(bpp_value);
      @(posedge clock);
      csr_index   <= CSR_ROW_LENGTH;
      csr_wr_data <= CSR_DATA_W'(len_value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.write_reg(CSR_BYTES_PER_PIXEL, CSR_DATA_W'(bpp_value));
      sb.write_reg(CSR_ROW_LENGTH, CSR_DATA_W'(len_value));
      row_size = (len_value < 1) ? 1 : ((len_value > ROW_STORE_DEPTH) ? ROW_STORE_DEPTH
                                                                     : len_value);
   endtask

   // A new image is forced when the line store holds no row long enough.
   function automatic logic row_start_flag();
      if (!upper_valid || row_size > stored_len) return 1'b1;
      return $urandom_range(0, 7) == 0;
   endfunction

   function automatic byte_type random_filter();
      if ($urandom_range(0, 7) == 0)
         return byte_type'($urandom_range(FILTER_UNKNOWN_LOW, FILTER_UNKNOWN_HIGH));
      return byte_type'($urandom_range(FILTER_NONE, FILTER_PAETH));
   endfunction

   // Main stimulus.
   initial begin
      int r, i, j, rows, bpp_pick, len_pick;
      sb              = new();
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.raw_byte    = '0;
      req.image_start = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_BYTES_PER_PIXEL;
      csr_wr_data     = '0;
      sender_idle     = 1'b0;
      receiver_idle   = 1'b0;
      row_size        = FIRST_ROW_LEN;
      stored_len      = 0;
      upper_valid     = 1'b0;
      random_items    = 0;
      idle_cycles     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two short rows under the reset pixel size, no idling.
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ROW_LENGTH;
      csr_wr_data <= CSR_DATA_W'(FIRST_ROW_LEN);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.write_reg(CSR_ROW_LENGTH, CSR_DATA_W'(FIRST_ROW_LEN));
      send_row(1'b1, FILTER_PAETH);
      send_row(1'b0, byte_type'($urandom_range(FILTER_NONE, FILTER_PAETH)));

      // Directed rows: one pixel per byte (size zero clamps to one).
      wait_for_pixels();
      write_config(0, DIRECTED_LEN);
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_byte(directed_filter[i], directed_start[i]);
         for (j = 0; j < DIRECTED_LEN; j++)
            send_byte(directed_data[i*DIRECTED_LEN + j],
                      directed_stray[i*DIRECTED_LEN + j]);
      end

      // Random phases with fresh settings and occasional full drains.
      while (random_items < RANDOM_ITEMS) begin
         wait_for_pixels();
         r = $urandom_range(0, 9);
         if (r < 4) bpp_pick = 3;
         else if (r < 8) bpp_pick = 4;
         else if (r == 8) bpp_pick = $urandom_range(0, 2);
         else bpp_pick = $urandom_range(5, 7);
         r = $urandom_range(0, 9);
         if (r == 0) len_pick = $urandom_range(0, 1);
         else if (r == 1) len_pick = $urandom_range(25, 64);
         else len_pick = $urandom_range(1, 24);
         write_config(bpp_pick, len_pick);
         sender_idle   = $urandom_range(0, 3) != 0;
         receiver_idle = $urandom_range(0, 3) != 0;
         rows = $urandom_range(2, 8);
         repeat (rows) begin
            send_row(row_start_flag(), random_filter());
            random_items += row_size + 1;
            if ($urandom_range(0, 9) == 0) wait_for_pixels();
         end
      end

      wait_for_pixels();
      repeat (END_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
         $display("png_scanline_unfilter test passed");
      end else begin
         $display("png_scanline_unfilter test failed");
      end
      $finish;
   end

endmodule

/* png_scanline_unfilter.f */
+incdir+hdl
hdl/pngu_pkg.sv
hdl/pngu_req_if.sv
hdl/pngu_rsp_if.sv
hdl/pngu_ram.sv
hdl/pngu_predict.sv
hdl/png_scanline_unfilter.sv
hdl/pngu_checker.sv
test/tb.sv
